[rtl/cartesian_to_polar_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the cartesian-to-polar converter
// Concurrent assertion wrappers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_TO_POLAR_MACROS_SVH
`define CARTESIAN_TO_POLAR_MACROS_SVH
`ifndef SYNTHESIS
// Assertion sampled on the rising clock edge and switched off during reset.
`define C2P_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Assertion that must also hold while reset is applied.
`define C2P_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define C2P_ASSERT(lbl, clk, rst_n, prop, msg)
`define C2P_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/c2p_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_pkg
// Widths, constants, control types and the arctangent table shared by the
// cartesian-to-polar converter.
// ----------------------------------------------------------------------------
package c2p_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int ANGLE_WIDTH  = 16;

  // CORDIC iterations and angle accumulator (binary angle, 2pi = 2^ACC_W).
  localparam int CORDIC_STEPS = 32;
  localparam int STEP_IDX_W   = $clog2(CORDIC_STEPS);
  localparam int ACC_W        = 32;

  // Coordinates are scaled up before the rotations so that the truncation of
  // the shifted terms stays far below one angle LSB.
  localparam int PRESHIFT     = 60 - COORD_WIDTH;
  // The rotated vector grows by the CORDIC gain (about 1.65) and by up to
  // sqrt(2) for a corner point; two guard bits hold that.
  localparam int CW           = COORD_WIDTH + PRESHIFT + 2;

  localparam int SQ_W         = 2 * COORD_WIDTH;
  localparam int REM_W        = COORD_WIDTH + 1;
  localparam int ANGLE_SHIFT  = ACC_W - ANGLE_WIDTH;

  localparam logic [ACC_W-1:0] ACC_HALF_TURN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic valid;
    logic origin;
  } c2p_ctl_t;

  // atan(2^-i) in units of 2pi/2^32.
  function automatic logic [ACC_W-1:0] atan_lut(input logic [STEP_IDX_W-1:0] idx);
    logic [ACC_W-1:0] val;
    case (idx)
      5'd0:    val = 32'h2000_0000;
      5'd1:    val = 32'h12E4_051E;
      5'd2:    val = 32'h09FB_385B;
      5'd3:    val = 32'h0511_11D4;
      5'd4:    val = 32'h028B_0D43;
      5'd5:    val = 32'h0145_D7E1;
      5'd6:    val = 32'h00A2_F61E;
      5'd7:    val = 32'h0051_7C55;
      5'd8:    val = 32'h0028_BE53;
      5'd9:    val = 32'h0014_5F2F;
      5'd10:   val = 32'h000A_2F98;
      5'd11:   val = 32'h0005_17CC;
      5'd12:   val = 32'h0002_8BE6;
      5'd13:   val = 32'h0001_45F3;
      5'd14:   val = 32'h0000_A2F9;
      5'd15:   val = 32'h0000_517D;
      5'd16:   val = 32'h0000_28BE;
      5'd17:   val = 32'h0000_145F;
      5'd18:   val = 32'h0000_0A30;
      5'd19:   val = 32'h0000_0518;
      5'd20:   val = 32'h0000_028C;
      5'd21:   val = 32'h0000_0146;
      5'd22:   val = 32'h0000_00A3;
      5'd23:   val = 32'h0000_0051;
      5'd24:   val = 32'h0000_0029;
      5'd25:   val = 32'h0000_0014;
      5'd26:   val = 32'h0000_000A;
      5'd27:   val = 32'h0000_0005;
      5'd28:   val = 32'h0000_0003;
      5'd29:   val = 32'h0000_0001;
      5'd30:   val = 32'h0000_0001;
      default: val = 32'h0000_0000;
    endcase
    return val;
  endfunction

endpackage

[rtl/c2p_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p channel interfaces
// Valid/ready channels for the input points and the polar results.
// ----------------------------------------------------------------------------
interface c2p_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [c2p_pkg::COORD_WIDTH-1:0]   x_coord;
  logic signed [c2p_pkg::COORD_WIDTH-1:0]   y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface c2p_out_if;
  logic                              valid;
  logic                              ready;
  logic [c2p_pkg::COORD_WIDTH-1:0]   radius;
  logic [c2p_pkg::ANGLE_WIDTH-1:0]   angle;

  modport source (output valid, output radius, output angle, input ready);
  modport sink   (input valid, input radius, input angle, output ready);
endinterface

[rtl/cartesian_to_polar.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_polar
// Pipelined rectangular-to-polar converter: radius by integer square root,
// angle by vectoring CORDIC.
// ----------------------------------------------------------------------------
// Converts each point (x_coord, y_coord), signed 16-bit, into its magnitude
// radius = round(sqrt(x^2 + y^2)) and its angle in [0, 2pi) as an unsigned
// binary angle in units of 2pi/65536 (rounded, a full turn wraps to 0); the
// origin gives radius 0 and angle 0. The block is a fully pipelined datapath:
// it takes one point per clock cycle while the pipeline is not frozen, and
// puts the results on the output in order. A point passes through the input
// stage, the 32 CORDIC rotation stages, one rotation per register stage, and
// the output register. The square root runs alongside in the same stages,
// one result bit per stage until the root is complete. A result that the
// consumer does not take at once is held in the output register and a skid
// slot behind it; only when both are full does the whole pipeline freeze and
// in_i.ready go low, so no transfer is ever lost or repeated. There is no
// configuration and no state besides the pipeline itself.
// ----------------------------------------------------------------------------
`include "cartesian_to_polar_macros.svh"

module cartesian_to_polar (
  input  logic        clk_i,
  input  logic        rst_ni,
  c2p_in_if.sink      in_i,
  c2p_out_if.source   out_o
);

  // Global advance: every pipeline register moves when the skid slot is free.
  logic                                advance;

  // Input stage to the rotation and root pipelines.
  c2p_pkg::c2p_ctl_t                   front_ctl;
  logic signed [c2p_pkg::CW-1:0]       front_x, front_y;
  logic [c2p_pkg::ACC_W-1:0]           front_z;
  logic [c2p_pkg::SQ_W-1:0]            front_sqx, front_sqy;

  // Last pipeline stage, taken by the output buffer.
  c2p_pkg::c2p_ctl_t                   last_ctl;
  logic [c2p_pkg::ACC_W-1:0]           last_z;
  logic [c2p_pkg::COORD_WIDTH-1:0]     last_root;
  logic [c2p_pkg::REM_W-1:0]           last_rem;

  // Squares the inputs, folds the left half plane and scales the vector.
  c2p_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .in_i   (in_i),
    .ctl_o  (front_ctl),
    .x_o    (front_x),
    .y_o    (front_y),
    .z_o    (front_z),
    .sqx_o  (front_sqx),
    .sqy_o  (front_sqy)
  );

  // 32 rotation stages; the valid and origin flags travel with the angle.
  c2p_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .ctl_i  (front_ctl),
    .x_i    (front_x),
    .y_i    (front_y),
    .z_i    (front_z),
    .ctl_o  (last_ctl),
    .z_o    (last_z)
  );

  // Square root of the sum of squares, the same depth as the rotations, so
  // root and angle of one point leave the pipeline together.
  c2p_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (advance),
    .sqx_i  (front_sqx),
    .sqy_i  (front_sqy),
    .root_o (last_root),
    .rem_o  (last_rem)
  );

  // Rounding and the output register with skid slot.
  c2p_outbuf u_outbuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (last_ctl),
    .z_i       (last_z),
    .root_i    (last_root),
    .rem_i     (last_rem),
    .advance_o (advance),
    .out_o     (out_o)
  );

  // Only the origin has radius zero, and its angle is defined as zero.
  `C2P_ASSERT_ALWAYS(a_origin_angle, clk_i, (out_o.valid && (out_o.radius == '0)) |-> (out_o.angle == '0), "zero radius with nonzero angle")

endmodule

[rtl/c2p_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_front
// Input stage: squares the coordinates, folds the left half plane onto the
// right one and scales the vector for the CORDIC rotations.
// ----------------------------------------------------------------------------
module c2p_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  c2p_in_if.sink                               in_i,
  output c2p_pkg::c2p_ctl_t                    ctl_o,
  output logic signed [c2p_pkg::CW-1:0]        x_o,
  output logic signed [c2p_pkg::CW-1:0]        y_o,
  output logic [c2p_pkg::ACC_W-1:0]            z_o,
  output logic [c2p_pkg::SQ_W-1:0]             sqx_o,
  output logic [c2p_pkg::SQ_W-1:0]             sqy_o
);

  localparam int CW = c2p_pkg::CW;
  localparam int N  = c2p_pkg::COORD_WIDTH;

  logic signed [CW-1:0]          xe, ye;
  logic                          neg;
  logic signed [c2p_pkg::SQ_W-1:0] sqx_w, sqy_w;

  c2p_pkg::c2p_ctl_t             ctl_d, ctl_q;
  logic signed [CW-1:0]          x_d, x_q, y_d, y_q;
  logic [c2p_pkg::ACC_W-1:0]     z_d, z_q;
  logic [c2p_pkg::SQ_W-1:0]      sqx_q, sqy_q;

  assign in_i.ready = en_i;

  assign xe  = {{(CW-N){in_i.x_coord[N-1]}}, in_i.x_coord};
  assign ye  = {{(CW-N){in_i.y_coord[N-1]}}, in_i.y_coord};
  assign neg = in_i.x_coord[N-1];

  assign sqx_w = in_i.x_coord * in_i.x_coord;
  assign sqy_w = in_i.y_coord * in_i.y_coord;

  always_comb begin
    ctl_d.valid  = in_i.valid;
    ctl_d.origin = (in_i.x_coord == '0) && (in_i.y_coord == '0);
    // A point in the left half plane is turned by half a turn first.
    x_d = (neg ? -xe : xe) <<< c2p_pkg::PRESHIFT;
    y_d = (neg ? -ye : ye) <<< c2p_pkg::PRESHIFT;
    z_d = neg ? c2p_pkg::ACC_HALF_TURN : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      sqx_q <= $unsigned(sqx_w);
      sqy_q <= $unsigned(sqy_w);
    end
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;
  assign sqx_o = sqx_q;
  assign sqy_o = sqy_q;

endmodule

[rtl/c2p_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_cordic
// Vectoring CORDIC, one rotation per register stage. Rotates the vector onto
// the positive x axis and accumulates the angle turned through.
// ----------------------------------------------------------------------------
`include "cartesian_to_polar_macros.svh"

module c2p_cordic (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  c2p_pkg::c2p_ctl_t                    ctl_i,
  input  logic signed [c2p_pkg::CW-1:0]        x_i,
  input  logic signed [c2p_pkg::CW-1:0]        y_i,
  input  logic [c2p_pkg::ACC_W-1:0]            z_i,
  output c2p_pkg::c2p_ctl_t                    ctl_o,
  output logic [c2p_pkg::ACC_W-1:0]            z_o
);

  localparam int CW    = c2p_pkg::CW;
  localparam int STEPS = c2p_pkg::CORDIC_STEPS;

  // The last stage needs only the sign of y, and the one before it no new x.
  logic signed [CW-1:0]          x_q   [STEPS-2];
  logic signed [CW-1:0]          y_q   [STEPS-1];
  logic [c2p_pkg::ACC_W-1:0]     z_q   [STEPS];
  c2p_pkg::c2p_ctl_t             ctl_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic signed [CW-1:0]        y_in;
    logic [c2p_pkg::ACC_W-1:0]   z_in, z_d, atan_k;
    c2p_pkg::c2p_ctl_t           ctl_in;
    logic                        pos;

    if (k == 0) begin : g_head
      assign y_in   = y_i;
      assign z_in   = z_i;
      assign ctl_in = ctl_i;
    end else begin : g_tail
      assign y_in   = y_q[k-1];
      assign z_in   = z_q[k-1];
      assign ctl_in = ctl_q[k-1];
    end

    assign atan_k = c2p_pkg::atan_lut(c2p_pkg::STEP_IDX_W'(k));
    assign pos    = !y_in[CW-1] && (y_in != '0);
    assign z_d    = pos ? (z_in + atan_k) : (z_in - atan_k);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else if (en_i) begin
        ctl_q[k] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[k] <= z_d;
      end
    end

    if (k <= STEPS - 2) begin : g_y
      logic signed [CW-1:0] x_in, y_d;

      if (k == 0) begin : g_head
        assign x_in = x_i;
      end else begin : g_tail
        assign x_in = x_q[k-1];
      end

      assign y_d = pos ? (y_in - (x_in >>> k)) : (y_in + (x_in >>> k));

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          y_q[k] <= y_d;
        end
      end

      if (k <= STEPS - 3) begin : g_x
        logic signed [CW-1:0] x_d;

        assign x_d = pos ? (x_in + (y_in >>> k)) : (x_in - (y_in >>> k));

        always_ff @(posedge clk_i) begin
          if (en_i) begin
            x_q[k] <= x_d;
          end
        end
      end
    end
  end

  assign ctl_o = ctl_q[STEPS-1];
  assign z_o   = z_q[STEPS-1];

  `C2P_ASSERT(a_frozen_holds, clk_i, rst_ni, !en_i |=> $stable(ctl_q[STEPS-1]), "CORDIC pipeline changed while frozen")

endmodule

[rtl/c2p_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_isqrt
// Sum of squares and digit-by-digit integer square root, one result bit per
// stage, padded to the depth of the CORDIC pipeline.
// ----------------------------------------------------------------------------
module c2p_isqrt (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [c2p_pkg::SQ_W-1:0]             sqx_i,
  input  logic [c2p_pkg::SQ_W-1:0]             sqy_i,
  output logic [c2p_pkg::COORD_WIDTH-1:0]      root_o,
  output logic [c2p_pkg::REM_W-1:0]            rem_o
);

  localparam int N     = c2p_pkg::COORD_WIDTH;
  localparam int SQ_W  = c2p_pkg::SQ_W;
  localparam int REM_W = c2p_pkg::REM_W;
  localparam int STEPS = c2p_pkg::CORDIC_STEPS;

  // Radicand bits still to be consumed, partial root and remainder.
  logic [SQ_W-1:0]   v_q   [N-1];
  logic [N-1:0]      r_q   [STEPS];
  logic [REM_W-1:0]  rem_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    logic [N-1:0]      r_d;
    logic [REM_W-1:0]  rem_d;

    if (k < N) begin : g_digit
      logic [SQ_W-1:0]   v_in;
      logic [N-1:0]      r_in;
      logic [REM_W-1:0]  rem_in;
      logic [REM_W+1:0]  rem_sh, trial;
      logic              ge;

      if (k == 0) begin : g_head
        assign v_in   = sqx_i + sqy_i;
        assign r_in   = '0;
        assign rem_in = '0;
      end else begin : g_tail
        assign v_in   = v_q[k-1];
        assign r_in   = r_q[k-1];
        assign rem_in = rem_q[k-1];
      end

      // Bring down the next two radicand bits and try root bit one.
      assign rem_sh = {rem_in, v_in[SQ_W-1 -: 2]};
      assign trial  = {1'b0, r_in, 2'b01};
      assign ge     = rem_sh >= trial;
      assign rem_d  = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      assign r_d    = {r_in[N-2:0], ge};

      if (k < N - 1) begin : g_shift
        always_ff @(posedge clk_i) begin
          if (en_i) begin
            v_q[k] <= v_in << 2;
          end
        end
      end
    end else begin : g_pad
      assign r_d   = r_q[k-1];
      assign rem_d = rem_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]   <= r_d;
        rem_q[k] <= rem_d;
      end
    end
  end

  assign root_o = r_q[STEPS-1];
  assign rem_o  = rem_q[STEPS-1];

endmodule

[rtl/c2p_outbuf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2p_outbuf
// Final rounding of radius and angle, and a two-entry output register with
// skid slot that decouples the pipeline from the result consumer.
// ----------------------------------------------------------------------------
`include "cartesian_to_polar_macros.svh"

module c2p_outbuf (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  c2p_pkg::c2p_ctl_t                    ctl_i,
  input  logic [c2p_pkg::ACC_W-1:0]            z_i,
  input  logic [c2p_pkg::COORD_WIDTH-1:0]      root_i,
  input  logic [c2p_pkg::REM_W-1:0]            rem_i,
  output logic                                 advance_o,
  c2p_out_if.source                            out_o
);

  localparam int ACC_W = c2p_pkg::ACC_W;
  localparam logic [ACC_W:0] RND_HALF =
    (ACC_W+1)'((64'd1 << c2p_pkg::ANGLE_SHIFT) >> 1);

  typedef struct packed {
    logic [c2p_pkg::COORD_WIDTH-1:0] radius;
    logic [c2p_pkg::ANGLE_WIDTH-1:0] angle;
  } res_t;

  res_t  res_w, out_d, out_q, skid_d, skid_q;
  logic  out_valid_d, out_valid_q, skid_valid_d, skid_valid_q;
  logic  push, take;
  logic  round_up;

  function automatic logic [c2p_pkg::REM_W-1:0] REM_W_ONE(input logic b);
    return {{(c2p_pkg::REM_W-1){1'b0}}, b};
  endfunction

  // Remainder above the root means the exact root lies past root + 1/2.
  assign round_up = rem_i > {1'b0, root_i};

  always_comb begin
    res_w.radius = c2p_pkg::COORD_WIDTH'({1'b0, root_i} + REM_W_ONE(round_up));
    res_w.angle  = c2p_pkg::ANGLE_WIDTH'(({1'b0, z_i} + RND_HALF) >> c2p_pkg::ANGLE_SHIFT);
    if (ctl_i.origin) begin
      res_w.angle = '0;
    end
  end

  assign advance_o = !skid_valid_q;
  assign push      = ctl_i.valid && advance_o;
  assign take      = out_valid_q && out_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d  = push;
        out_d        = res_w;
      end
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_d       = res_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.radius = out_q.radius;
  assign out_o.angle  = out_q.angle;

  `C2P_ASSERT(a_skid_behind_out, clk_i, rst_ni, skid_valid_q |-> out_valid_q, "skid slot full while output register empty")
  `C2P_ASSERT(a_skid_kept, clk_i, rst_ni, (skid_valid_q && !take) |=> skid_valid_q, "skid entry dropped without a transfer")
  `C2P_ASSERT(a_skid_drain, clk_i, rst_ni, (skid_valid_q && take) |=> (out_valid_q && !skid_valid_q), "skid entry not moved to the output register")

endmodule

[test/cartesian_to_polar_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_to_polar_test
// Self-checking testbench for the rectangular-to-polar converter. A table of
// directed points (origin, axes, corners, wrap cases) is followed by a random
// mix of points. Points without a hand-typed result go through a bit-exact
// model of the square root and the CORDIC vectoring. The expected radius and
// angle are queued in order and compared with each result transfer. Both
// channels idle at random, with one long output stall and one full drain.
// ----------------------------------------------------------------------------
module cartesian_to_polar_test;

  localparam int CW            = c2p_pkg::COORD_WIDTH;
  localparam int AW            = c2p_pkg::ANGLE_WIDTH;
  // Binary-angle accumulator of the angle model: a full turn is 2^32.
  localparam int TURN_W        = 32;
  localparam int ROT_STEPS     = 32;
  localparam int SCALE_SHIFT   = 60 - CW;
  localparam int ROUND_SHIFT   = TURN_W - AW;

  localparam int NUM_POINTS    = 1650;
  localparam int NUM_DIRECTED  = 22;
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_AT       = 300;
  localparam int DRAIN_AT      = 1000;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_LIMIT    = 2000;

  // atan(2^-i) in units of 2pi/2^32.
  localparam logic [TURN_W-1:0] ATAN_STEP [ROT_STEPS] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
    32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
    32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
  };

  // Coordinates that sit at or next to the ends and the middle of the range.
  localparam int EDGE_VALUES [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

  typedef struct packed {
    logic [CW-1:0] radius;
    logic [AW-1:0] angle;
  } polar_t;

  // One expected result, with the point that caused it for the messages.
  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    polar_t               polar;
  } pending_t;

  // A directed point; where fixed is set, the result is typed in by hand.
  typedef struct {
    int x;
    int y;
    bit fixed;
    int radius;
    int angle;
  } stim_row_t;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{     0,      0, 1,     0,     0},  // origin
    '{    -1,      0, 1,     1, 32768},  // negative x axis: half a turn
    '{-32768,      0, 1, 32768, 32768},
    '{-12345,      0, 1, 12345, 32768},
    '{ 32767,      0, 0,     0,     0},  // positive x axis
    '{     1,      0, 0,     0,     0},
    '{     0,      1, 0,     0,     0},  // y axis both ways
    '{     0,  32767, 0,     0,     0},
    '{     0,     -1, 0,     0,     0},
    '{     0, -32768, 0,     0,     0},
    '{ 32767,  32767, 0,     0,     0},  // corners, largest radius
    '{-32768, -32768, 0,     0,     0},
    '{ 32767, -32768, 0,     0,     0},
    '{-32768,  32767, 0,     0,     0},
    '{     1,     -1, 0,     0,     0},
    '{ 32767,     -1, 0,     0,     0},  // just below a full turn: wraps to 0
    '{     1,      1, 0,     0,     0},
    '{    -1,     -1, 0,     0,     0},
    '{     3,      4, 0,     0,     0},
    '{    -5,     12, 0,     0,     0},
    '{ 21845, -21846, 0,     0,     0},  // alternating bit patterns
    '{-10923,  10922, 0,     0,     0}
  };

  logic clk_i;
  logic rst_ni;

  c2p_in_if  in_if ();
  c2p_out_if out_if ();

  cartesian_to_polar dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  pending_t expected_polar [$];
  int       error_count;
  int       num_points;
  int       num_results;
  int       num_on_axis;
  int       num_at_edge;
  int       idle_cycles;
  bit       hold_request;
  bit       hold_done;
  bit       drain_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Polar form of one point. The radius is the integer square root of
  // x^2 + y^2, found bit by bit and then rounded to nearest. The angle runs
  // 32 vectoring rotations on coordinates scaled up by 2^SCALE_SHIFT; a point
  // in the left half plane is first turned by half a turn. The 32-bit binary
  // angle is rounded to the output width, so that a full turn wraps to 0.
  function automatic polar_t to_polar(input logic signed [CW-1:0] x,
                                      input logic signed [CW-1:0] y);
    polar_t             res;
    longint             px;
    longint             py;
    longint             dx;
    longint             dy;
    longint unsigned    sq;
    longint unsigned    root;
    longint unsigned    trial;
    logic [TURN_W-1:0]  turn;
    logic [TURN_W:0]    rounded;
    res = '0;
    if (x == 0 && y == 0) begin
      return res;
    end
    px = longint'(x);
    py = longint'(y);
    sq = px * px + py * py;
    root = '0;
    for (int b = CW; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sq) begin
        root = trial;
      end
    end
    if (sq > root * root + root) begin
      root = root + 64'd1;
    end
    turn = '0;
    if (px < 0) begin
      px = -px;
      py = -py;
      turn = {1'b1, {(TURN_W-1){1'b0}}};
    end
    px = px <<< SCALE_SHIFT;
    py = py <<< SCALE_SHIFT;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = px >>> i;
      dy = py >>> i;
      if (py > 0) begin
        px = px + dy;
        py = py - dx;
        turn = turn + ATAN_STEP[i];
      end else begin
        px = px - dy;
        py = py + dx;
        turn = turn - ATAN_STEP[i];
      end
    end
    rounded = {1'b0, turn} + ((TURN_W+1)'(1) << (ROUND_SHIFT - 1));
    res.radius = root[CW-1:0];
    res.angle  = rounded[ROUND_SHIFT +: AW];
    return res;
  endfunction

  // Offers one point after a gap and waits for its transfer. Called just
  // after a falling edge; returns after the falling edge that follows the
  // transfer, valid still high so a following point can go back to back.
  task automatic send_point(input logic signed [CW-1:0] x,
                            input logic signed [CW-1:0] y,
                            input polar_t want, input int gap);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.x_coord <= x;
    in_if.y_coord <= y;
    do @(posedge clk_i); while (!in_if.ready);
    expected_polar.push_back('{x: x, y: y, polar: want});
    num_points++;
    if (x == 0 || y == 0) num_on_axis++;
    if (x == -32768 || x == 32767 || y == -32768 || y == 32767) num_at_edge++;
    @(negedge clk_i);
  endtask

  // Point source: the directed table, then the random mix.
  initial begin
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    polar_t               want;
    int                   kind;
    bit                   calm;
    in_if.valid   = 1'b0;
    in_if.x_coord = '0;
    in_if.y_coord = '0;
    hold_request  = 1'b0;
    rst_ni        = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: hand-typed results where they are plain to see, the
    // predictor everywhere else.
    foreach (directed_rows[r]) begin
      x = CW'(directed_rows[r].x);
      y = CW'(directed_rows[r].y);
      if (directed_rows[r].fixed) begin
        want.radius = CW'(directed_rows[r].radius);
        want.angle  = AW'(directed_rows[r].angle);
      end else begin
        want = to_polar(x, y);
      end
      send_point(x, y, want, $urandom_range(0, 8));
    end

    for (int i = 0; i < NUM_POINTS - NUM_DIRECTED; i++) begin
      // Every fourth block of a hundred points goes out without gaps. The
      // long output stall starts at the head of such a block, so the
      // pipeline fills and the input is pushed back.
      calm = ((i / 100) % 4) == 3;
      if (i == HOLD_AT) begin
        hold_request = 1'b1;
      end
      // Once, the source stops until every result is back.
      if (i == DRAIN_AT) begin
        in_if.valid <= 1'b0;
        do @(negedge clk_i); while (expected_polar.size() != 0);
        drain_done = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        x = CW'($urandom);
        y = CW'($urandom);
      end else if (kind < 65) begin
        // Close to the origin, where the angle steps are coarse.
        x = CW'($urandom_range(0, 8) - 4);
        y = CW'($urandom_range(0, 8) - 4);
      end else if (kind < 80) begin
        // Near an axis, including the wrap just below a full turn.
        x = CW'($urandom);
        y = CW'($urandom_range(0, 4) - 2);
        if ($urandom_range(0, 1)) begin
          {x, y} = {y, x};
        end
      end else if (kind < 90) begin
        x = CW'(EDGE_VALUES[$urandom_range(0, 6)]);
        y = CW'(EDGE_VALUES[$urandom_range(0, 6)]);
      end else begin
        // On a diagonal.
        x = CW'($urandom);
        y = $urandom_range(0, 1) ? x : -x;
      end
      send_point(x, y, to_polar(x, y), calm ? 0 : $urandom_range(0, 8));
    end
    in_if.valid <= 1'b0;

    // Let the pipeline empty, then leave room for any stray result.
    while (expected_polar.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (expected_polar.size() != 0) begin
      $error("%0d expected results never arrived", expected_polar.size());
      error_count++;
    end
    $display("Converted %0d points (%0d from the table), checked %0d results.",
             num_points, NUM_DIRECTED, num_results);
    $display("%0d points on an axis, %0d at the range ends; long stall %0s, drain %0s.",
             num_on_axis, num_at_edge, hold_done ? "seen" : "missed",
             drain_done ? "seen" : "missed");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result sink: random stalls between transfers, stretches without stalls,
  // and one long hold-off on request from the source.
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_done    = 1'b1;
        stall        = LONG_HOLD;
      end else if (((num_results / 64) % 3) == 2) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 8);
      end
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      @(negedge clk_i);
    end
  end

  // Compares each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    pending_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      num_results++;
      if (expected_polar.size() == 0) begin
        $error("result with nothing expected: radius %0d angle %0d",
               out_if.radius, out_if.angle);
        error_count++;
      end else begin
        want = expected_polar.pop_front();
        if (out_if.radius !== want.polar.radius) begin
          $error("radius for (%0d,%0d): expected %0d, actual %0d",
                 want.x, want.y, want.polar.radius, out_if.radius);
          error_count++;
        end
        if (out_if.angle !== want.polar.angle) begin
          $error("angle for (%0d,%0d): expected %0d, actual %0d",
                 want.x, want.y, want.polar.angle, out_if.angle);
          error_count++;
        end
      end
    end
  end

  // Ends a run in which no transfer on either channel happens for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("No transfer for %0d cycles, %0d results outstanding.",
                 IDLE_LIMIT, expected_polar.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule
